// ----- hw/rtl/sogc_pkg.sv -----
// ----------------------------------------------------------------------------
// Segment overlap grid counter package
// Grid geometry, field widths, status codes and the beat payload types that
// the counter uses; the hit memory does not import this package.
// ----------------------------------------------------------------------------
package sogc_pkg;

   // Grid geometry. Cells are stored row by row: address = row * side + col.
   localparam int GRID_SIDE  = 1024;
   localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
   localparam int CELL_AW    = $clog2(GRID_CELLS);

   // Coordinate fields are fixed at ten bits whatever the grid side.
   localparam int COORD_W = 10;
   localparam int SIDE_W  = $clog2(GRID_SIDE + 1);
   localparam int CMP_W   = (COORD_W > SIDE_W) ? COORD_W : SIDE_W;

   // Per-cell hit counter saturates at two.
   localparam int          HIT_W   = 2;
   localparam logic [HIT_W-1:0] HIT_ONE = 2'd1;
   localparam logic [HIT_W-1:0] HIT_MAX = 2'd2;

   // Running overlap count saturates at all ones.
   localparam int               TOTAL_W   = 21;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   typedef enum logic [1:0] {
      STATUS_DRAWN     = 2'd0,
      STATUS_DIAG_OFF  = 2'd1,
      STATUS_BAD_SLOPE = 2'd2
   } status_type;

   typedef struct packed {
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
   } req_payload_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] overlap_cells;
      status_type         draw_status;
   } rsp_payload_type;

endpackage

// ----- hw/rtl/sogc_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered, so it appears
// in the cycle after a read address taken with rd_en. No reset on the storage.
// ----------------------------------------------------------------------------
module sogc_ram #(
   parameter int WIDTH  = 2,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/segment_overlap_grid_counter_unit.sv -----
// ----------------------------------------------------------------------------
// Segment overlap grid counter: an accepted segment is walked cell by cell,
// then its result beat is registered from the finish state and the next
// segment is taken back in the idle state; a skipped segment goes from idle
// straight to finish. A stalled result beat holds off the next result beat.
// One hit-memory read-modify-write per in-grid cell. After reset a clearing
// pass writes every cell while no segment is accepted.
// ----------------------------------------------------------------------------
module segment_overlap_grid_counter_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  sogc_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output sogc_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_wr_en,
   input  logic                      csr_wr_data
);

   import sogc_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   state_type            state_ff, state_in;
   logic                 diag_en_ff, diag_en_in;
   logic [COORD_W-1:0]   x_ff, x_in;
   logic [COORD_W-1:0]   y_ff, y_in;
   logic [COORD_W-1:0]   end_x_ff, end_x_in;
   logic [COORD_W-1:0]   end_y_ff, end_y_in;
   logic [COORD_W-1:0]   cnt_ff, cnt_in;
   status_type           status_ff, status_in;
   logic [CELL_AW-1:0]   clr_ff, clr_in;
   logic                 pend_ff, pend_in;
   logic [CELL_AW-1:0]   wr_addr_ff, wr_addr_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_payload_ff, rsp_payload_in;

   logic                 req_take;
   logic                 out_free;
   logic [COORD_W-1:0]   adx, ady;
   status_type           req_status;
   logic                 in_grid;
   logic [CELL_AW-1:0]   cell_addr;
   logic                 ram_rd_en;
   logic                 ram_wr_en;
   logic [CELL_AW-1:0]   ram_wr_addr;
   logic [HIT_W-1:0]     ram_wr_data;
   logic [HIT_W-1:0]     rd_hits;
   logic                 total_inc;

   // Input beats are taken only while no segment is in flight.
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Classify the incoming segment by its absolute extents.
   always_comb begin
      adx = (req_payload.end_x >= req_payload.start_x) ?
            req_payload.end_x - req_payload.start_x :
            req_payload.start_x - req_payload.end_x;
      ady = (req_payload.end_y >= req_payload.start_y) ?
            req_payload.end_y - req_payload.start_y :
            req_payload.start_y - req_payload.end_y;
      priority if (adx == '0 || ady == '0) begin
         req_status = STATUS_DRAWN;
      end else if (adx == ady) begin
         req_status = diag_en_ff ? STATUS_DRAWN : STATUS_DIAG_OFF;
      end else begin
         req_status = STATUS_BAD_SLOPE;
      end
   end

   // Current cell address; cells beyond the grid edge are stepped over.
   assign in_grid   = (CMP_W'(x_ff) < CMP_W'(GRID_SIDE)) &&
                      (CMP_W'(y_ff) < CMP_W'(GRID_SIDE));
   assign cell_addr = CELL_AW'(CELL_AW'(y_ff) * CELL_AW'(GRID_SIDE) + CELL_AW'(x_ff));
   assign ram_rd_en = (state_ff == ST_WALK) && in_grid;

   // Modify stage: the hit count read last cycle is bumped and written back.
   assign total_inc = pend_ff && (rd_hits == HIT_ONE) && (total_ff != TOTAL_MAX);
   assign total_in  = total_inc ? total_ff + TOTAL_W'(1) : total_ff;

   // The clearing pass owns the write port until it is done.
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = pend_ff && (rd_hits < HIT_MAX);
         ram_wr_addr = wr_addr_ff;
         ram_wr_data = rd_hits + HIT_W'(1);
      end
   end

   sogc_ram #(
      .WIDTH (HIT_W),
      .DEPTH (GRID_CELLS)
   ) u_hits (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (cell_addr),
      .rd_data (rd_hits)
   );

   // Sequencer next state.
   always_comb begin
      state_in       = state_ff;
      diag_en_in     = csr_wr_en ? csr_wr_data : diag_en_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      end_x_in       = end_x_ff;
      end_y_in       = end_y_ff;
      cnt_in         = cnt_ff;
      status_in      = status_ff;
      clr_in         = clr_ff;
      pend_in        = ram_rd_en;
      wr_addr_in     = cell_addr;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + CELL_AW'(1);
            if (clr_ff == CELL_AW'(GRID_CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               x_in      = req_payload.start_x;
               y_in      = req_payload.start_y;
               end_x_in  = req_payload.end_x;
               end_y_in  = req_payload.end_y;
               cnt_in    = (adx > ady) ? adx : ady;
               status_in = req_status;
               state_in  = (req_status == STATUS_DRAWN) ? ST_WALK : ST_FINISH;
            end
         end
         ST_WALK: begin
            // Step one cell toward the end point on each axis.
            if (x_ff < end_x_ff) begin
               x_in = x_ff + COORD_W'(1);
            end else if (x_ff > end_x_ff) begin
               x_in = x_ff - COORD_W'(1);
            end
            if (y_ff < end_y_ff) begin
               y_in = y_ff + COORD_W'(1);
            end else if (y_ff > end_y_ff) begin
               y_in = y_ff - COORD_W'(1);
            end
            cnt_in = cnt_ff - COORD_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // The last write-back lands on entering this state.
            if (out_free) begin
               rsp_valid_in                 = 1'b1;
               rsp_payload_in.overlap_cells = total_in;
               rsp_payload_in.draw_status   = status_ff;
               state_in                     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, counters and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         diag_en_ff   <= 1'b1;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         diag_en_ff   <= diag_en_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff           <= x_in;
      y_ff           <= y_in;
      end_x_ff       <= end_x_in;
      end_y_ff       <= end_y_in;
      cnt_ff         <= cnt_in;
      status_ff      <= status_in;
      wr_addr_ff     <= wr_addr_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // A pending write-back never survives into the idle state.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_ff)
      else $error("write-back pending while idle");

   // A read and a write-back never hit the same cell in one cycle.
   assert property (@(posedge clock) disable iff (reset)
      ram_wr_en && ram_rd_en |-> ram_wr_addr != cell_addr)
      else $error("hit memory read and write collide");

   // The running overlap count never goes down.
   assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_CLEAR |=> total_ff >= $past(total_ff))
      else $error("overlap count decreased");

   // An accepted segment moves the sequencer into walking or finishing.
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_WALK || state_ff == ST_FINISH)
      else $error("accepted beat left sequencer idle");

endmodule
